[sv/tes_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants for the text encoding sniffer
// Encoding codes, byte order mark patterns and the per-buffer scan state.
// ----------------------------------------------------------------------------
package tes_pkg;

    typedef enum logic [2:0] {
        ENC_UNKNOWN     = 3'd0,
        ENC_UNSUPPORTED = 3'd1,
        ENC_UTF8_BOM    = 3'd2,
        ENC_UTF8        = 3'd3,
        ENC_LATIN1      = 3'd4,
        ENC_ASCII       = 3'd5
    } encoding_t;

    // Leading bytes as stored: first byte in bits 7:0
    localparam logic [31:0] BOM_UTF32_LE = 32'h0000_FEFF; // FF FE 00 00
    localparam logic [31:0] BOM_UTF32_BE = 32'hFFFE_0000; // 00 00 FE FF
    localparam logic [23:0] BOM_UTF8     = 24'hBF_BBEF;   // EF BB BF
    localparam logic [15:0] BOM_UTF16_LE = 16'hFEFF;      // FF FE
    localparam logic [15:0] BOM_UTF16_BE = 16'hFFFE;      // FE FF

    localparam logic [2:0] LEAD_DEPTH = 3'd4;
    localparam logic [2:0] MIN_BYTES  = 3'd2;

    typedef struct packed {
        logic [31:0] leading_bytes;
        logic [2:0]  bytes_seen;
        logic [7:0]  prior_byte;
        logic        utf8_ok;
        logic        latin_control_seen;
        logic        high_byte_seen;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        leading_bytes:      32'h0,
        bytes_seen:         3'd0,
        prior_byte:         8'h00,
        utf8_ok:            1'b1,
        latin_control_seen: 1'b0,
        high_byte_seen:     1'b0
    };

endpackage : tes_pkg
`default_nettype wire

[sv/tes_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tes_scan: per-byte state update and encoding decision
// Folds one byte into the scan state and classifies the buffer from the
// updated state; combinational only.
// ----------------------------------------------------------------------------
module tes_scan (
    input  var tes_pkg::scan_state_t cur,
    input  var logic [7:0]           data_byte,
    output var tes_pkg::scan_state_t upd,
    output var tes_pkg::encoding_t   encoding
);
    import tes_pkg::*;

    logic bad_lead;
    logic orphan_tail;
    logic prev_tail;
    logic prev_lead;

    always_comb
    begin
        prev_tail   = cur.prior_byte inside {[8'h80:8'hBF]};
        prev_lead   = cur.prior_byte inside {[8'hC2:8'hF4]};
        bad_lead    = data_byte inside {8'h00, 8'hC0, 8'hC1, [8'hF5:8'hFF]};
        orphan_tail = (data_byte inside {[8'h80:8'hBF]}) && !prev_tail && !prev_lead;

        upd = cur;
        if (cur.bytes_seen < LEAD_DEPTH)
        begin
            upd.leading_bytes[cur.bytes_seen[1:0]*8 +: 8] = data_byte;
            upd.bytes_seen = cur.bytes_seen + 3'd1;
        end
        if (bad_lead || orphan_tail)
        begin
            upd.utf8_ok = 1'b0;
        end
        if (data_byte inside {[8'h80:8'h9F]})
        begin
            upd.latin_control_seen = 1'b1;
        end
        if (data_byte[7])
        begin
            upd.high_byte_seen = 1'b1;
        end
        upd.prior_byte = data_byte;
    end

    // Too-short buffers first, then marks, then the running flags
    always_comb
    begin
        if (upd.bytes_seen < MIN_BYTES)
        begin
            encoding = ENC_UNKNOWN;
        end
        else if (upd.leading_bytes == BOM_UTF32_LE || upd.leading_bytes == BOM_UTF32_BE)
        begin
            encoding = ENC_UNSUPPORTED;
        end
        else if (upd.leading_bytes[23:0] == BOM_UTF8)
        begin
            encoding = ENC_UTF8_BOM;
        end
        else if (upd.leading_bytes[15:0] == BOM_UTF16_LE ||
                 upd.leading_bytes[15:0] == BOM_UTF16_BE)
        begin
            encoding = ENC_UNSUPPORTED;
        end
        else if (upd.utf8_ok)
        begin
            encoding = ENC_UTF8;
        end
        else if (upd.latin_control_seen)
        begin
            encoding = ENC_LATIN1;
        end
        else if (!upd.high_byte_seen)
        begin
            encoding = ENC_ASCII;
        end
        else
        begin
            encoding = ENC_UNKNOWN;
        end
    end

endmodule : tes_scan
`default_nettype wire

[sv/text_encoding_sniffer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_encoding_sniffer_top: byte order mark and UTF-8 encoding detection
// Result path: the last word of a buffer is taken into the input register, and
//   its code is then loaded into the result register once the result slot is free.
// Throughput: one word per cycle; an end word waits in the input register
//   only while the previous result is still unclaimed.
// Reset: rst_n clears the scan state to its initial values and drops both
//   valid registers; the state also returns to that value after each buffer.
// ----------------------------------------------------------------------------
module text_encoding_sniffer_top (
    input  var logic       clk,
    input  var logic       rst_n,
    input  var logic       in_valid,
    output var logic       in_ready,
    input  var logic [7:0] data_byte,
    input  var logic       last_byte,
    output var logic       out_valid,
    input  var logic       out_ready,
    output var logic [2:0] encoding
);
    import tes_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t state_upd;
    encoding_t   enc_comb;
    logic        out_valid_reg;
    logic        out_valid_next;
    encoding_t   enc_reg;
    logic        out_free;
    logic        s1_go;

    assign out_free = !out_valid_reg || out_ready;
    // A word without the end flag makes no result and never waits
    assign s1_go    = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_go;

    tes_scan u_scan (
        .cur       (state_reg),
        .data_byte (s1_byte_reg),
        .upd       (state_upd),
        .encoding  (enc_comb)
    );

    always_comb
    begin
        s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_go)
        begin
            // Clear the state once a buffer closes
            state_next = s1_last_reg ? SCAN_RESET : state_upd;
            if (s1_last_reg)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= SCAN_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_go && s1_last_reg)
        begin
            enc_reg <= enc_comb;
        end
    end

    assign out_valid = out_valid_reg;
    assign encoding  = enc_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes_seen <= LEAD_DEPTH)
        else $error("byte count beyond saturation");

    a_latin_implies_high: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.latin_control_seen |-> state_reg.high_byte_seen)
        else $error("control byte flag without high byte flag");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last_reg) |=> (state_reg.bytes_seen == 3'd0 && state_reg.utf8_ok))
        else $error("scan state not cleared after buffer end");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && !out_free) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("end word lost while result slot busy");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (enc_reg <= ENC_ASCII))
        else $error("encoding code out of range");

endmodule : text_encoding_sniffer_top
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for text_encoding_sniffer_top
// Streams text buffers one byte word at a time, predicts the encoding code of
// each buffer from a behavioural scan of its bytes and checks every result
// against the oldest prediction, under several idling and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

    import tes_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_GAP      = 8;

    typedef enum int unsigned {
        TEXT_ASCII,
        TEXT_UTF8,
        TEXT_MARKED,
        TEXT_LATIN,
        TEXT_NOISE
    } text_kind_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] encoding;

    // Scan state of the predictor
    logic [31:0] lead_bytes;
    logic [2:0]  lead_count;
    logic [7:0]  prev_byte;
    logic        utf8_valid;
    logic        control_seen;
    logic        high_seen;

    encoding_t   pending_codes[$];
    logic [7:0]  text_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;

    text_encoding_sniffer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .encoding  (encoding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: a requested hold-off takes priority over random stalls
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Results are sampled mid-cycle; the handshake completes at the next edge
    always @(negedge clk)
    begin
        encoding_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("encoding: no result expected, got %0d", encoding);
                fail_count++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (encoding !== want)
                begin
                    $error("encoding: expected %0d, got %0d", want, encoding);
                    fail_count++;
                end
            end
        end
    end

    function automatic void clear_scan();
        lead_bytes   = 32'h0;
        lead_count   = 3'd0;
        prev_byte    = 8'h00;
        utf8_valid   = 1'b1;
        control_seen = 1'b0;
        high_seen    = 1'b0;
    endfunction

    function automatic encoding_t classify_buffer();
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        b0 = lead_bytes[7:0];
        b1 = lead_bytes[15:8];
        b2 = lead_bytes[23:16];
        b3 = lead_bytes[31:24];
        if (lead_count < 3'd2)
            return ENC_UNKNOWN;
        if ((b0 == 8'hFF && b1 == 8'hFE && b2 == 8'h00 && b3 == 8'h00) ||
            (b0 == 8'h00 && b1 == 8'h00 && b2 == 8'hFE && b3 == 8'hFF))
            return ENC_UNSUPPORTED;
        if (b0 == 8'hEF && b1 == 8'hBB && b2 == 8'hBF)
            return ENC_UTF8_BOM;
        if ((b0 == 8'hFF && b1 == 8'hFE) || (b0 == 8'hFE && b1 == 8'hFF))
            return ENC_UNSUPPORTED;
        if (utf8_valid)
            return ENC_UTF8;
        if (control_seen)
            return ENC_LATIN1;
        if (!high_seen)
            return ENC_ASCII;
        return ENC_UNKNOWN;
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic is_last);
        logic prev_tail;
        logic prev_lead;
        prev_tail = (prev_byte >= 8'h80 && prev_byte <= 8'hBF);
        prev_lead = (prev_byte >= 8'hC2 && prev_byte <= 8'hF4);
        if (lead_count < 3'd4)
        begin
            lead_bytes = lead_bytes | (32'(b) << (8 * lead_count));
            lead_count = lead_count + 3'd1;
        end
        if (b == 8'h00 || b == 8'hC0 || b == 8'hC1 || b >= 8'hF5)
            utf8_valid = 1'b0;
        if (b >= 8'h80 && b <= 8'hBF && !prev_tail && !prev_lead)
            utf8_valid = 1'b0;
        if (b >= 8'h80 && b <= 8'h9F)
            control_seen = 1'b1;
        if (b > 8'h7F)
            high_seen = 1'b1;
        prev_byte = b;
        if (is_last)
        begin
            pending_codes.push_back(classify_buffer());
            clear_scan();
        end
    endtask

    // Offer one word; called and returning just after a rising edge
    task automatic send_word(input logic [7:0] b, input logic is_last);
        int unsigned gap;
        logic        taken;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        scan_byte(b, is_last);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_word(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_short(input int n, input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
        text_q.delete();
        text_q.push_back(b0);
        if (n > 1) text_q.push_back(b1);
        if (n > 2) text_q.push_back(b2);
        if (n > 3) text_q.push_back(b3);
        send_text();
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        @(posedge clk);
    endtask

    // Hold the input, then let every outstanding result arrive
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_utf8_char();
        int unsigned width;
        width = $urandom_range(4, 1);
        case (width)
            1: text_q.push_back(8'($urandom_range(8'h7F, 8'h01)));
            2: text_q.push_back(8'($urandom_range(8'hDF, 8'hC2)));
            3: text_q.push_back(8'($urandom_range(8'hEF, 8'hE0)));
            default: text_q.push_back(8'($urandom_range(8'hF4, 8'hF0)));
        endcase
        for (int i = 1; i < width; i++)
            text_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
    endtask

    task automatic add_mark();
        int unsigned pick;
        int unsigned keep;
        logic [7:0]  mark[4];
        int unsigned mark_len;
        pick = $urandom_range(4);
        mark_len = 4;
        case (pick)
            0: mark = '{8'hFF, 8'hFE, 8'h00, 8'h00};
            1: mark = '{8'h00, 8'h00, 8'hFE, 8'hFF};
            2: begin mark = '{8'hEF, 8'hBB, 8'hBF, 8'h00}; mark_len = 3; end
            3: begin mark = '{8'hFF, 8'hFE, 8'h00, 8'h00}; mark_len = 2; end
            default: begin mark = '{8'hFE, 8'hFF, 8'h00, 8'h00}; mark_len = 2; end
        endcase
        // Cut some marks short so that partial matches get exercised
        keep = ($urandom_range(3) == 0) ? $urandom_range(mark_len - 1, 1) : mark_len;
        for (int i = 0; i < keep; i++)
            text_q.push_back(mark[i]);
    endtask

    task automatic build_text();
        text_kind_t  kind;
        int unsigned roll;
        int unsigned chars;
        roll = $urandom_range(99);
        if (roll < 20)
            kind = TEXT_ASCII;
        else if (roll < 50)
            kind = TEXT_UTF8;
        else if (roll < 70)
            kind = TEXT_MARKED;
        else if (roll < 85)
            kind = TEXT_LATIN;
        else
            kind = TEXT_NOISE;
        roll = $urandom_range(99);
        if (roll < 5)
            chars = 1;
        else if (roll < 10)
            chars = $urandom_range(40, 20);
        else
            chars = $urandom_range(12, 2);
        text_q.delete();
        case (kind)
            TEXT_ASCII:
                for (int i = 0; i < chars; i++)
                    text_q.push_back(8'($urandom_range(3) == 0 ? $urandom_range(8'h7F)
                                                             : $urandom_range(8'h7E, 8'h20)));
            TEXT_UTF8:
                for (int i = 0; i < chars; i++)
                    add_utf8_char();
            TEXT_MARKED:
            begin
                add_mark();
                chars = $urandom_range(6);
                for (int i = 0; i < chars; i++)
                    add_utf8_char();
            end
            TEXT_LATIN:
                for (int i = 0; i < chars; i++)
                    text_q.push_back(8'($urandom_range(1) ? $urandom_range(8'hFF, 8'h80)
                                                          : $urandom_range(8'h7E, 8'h20)));
            default:
                for (int i = 0; i < chars; i++)
                    text_q.push_back(8'($urandom_range(8'hFF)));
        endcase
    endtask

    task automatic test_directed();
        send_short(1, 8'h41, 8'h00, 8'h00, 8'h00);  // too short to classify
        send_short(4, 8'hFF, 8'hFE, 8'h00, 8'h00);  // UTF-32 LE mark
        send_short(4, 8'h00, 8'h00, 8'hFE, 8'hFF);  // UTF-32 BE mark
        send_short(3, 8'hEF, 8'hBB, 8'hBF, 8'h00);  // UTF-8 mark
        send_short(2, 8'hFE, 8'hFF, 8'h00, 8'h00);  // UTF-16 BE mark
        send_short(2, 8'hC3, 8'hA9, 8'h00, 8'h00);  // valid UTF-8
        send_short(2, 8'h41, 8'h85, 8'h00, 8'h00);  // stray tail in control range
        send_short(2, 8'h7F, 8'hFF, 8'h00, 8'h00);  // high byte, no control byte
        send_short(2, 8'h41, 8'h00, 8'h00, 8'h00);  // NUL breaks UTF-8, still ASCII
        send_short(2, 8'hC0, 8'h80, 8'h00, 8'h00);  // overlong lead
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct,
                                       input int unsigned n_words);
        int unsigned sent;
        set_idling(send_pct, stall_pct);
        sent = 0;
        while (sent < n_words)
        begin
            build_text();
            send_text();
            sent += text_q.size();
        end
        wait_drained();
    endtask

    // Stall the output for a long stretch while short buffers keep coming
    task automatic test_backpressure();
        set_idling(0, 0);
        @(negedge clk);
        hold_request = 300;
        @(posedge clk);
        for (int i = 0; i < 40; i++)
            send_short(2, 8'($urandom_range(8'hFF)), 8'($urandom_range(8'hFF)),
                       8'h00, 8'h00);
        wait_drained();
    endtask

    initial
    begin
        clear_scan();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(0, 0, 300);
        test_random_traffic(70, 0, 300);
        test_random_traffic(0, 70, 300);
        test_random_traffic(25, 25, 300);
        test_backpressure();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
